// ===== rtl/core/efth_pkg.sv =====
// Shared constants, codes and types for the 3x3 thresholded edge filter.
package efth_pkg;

   // default geometry
   localparam int DEF_MAX_WIDTH  = 128;
   localparam int DEF_MAX_HEIGHT = 128;
   localparam int DEF_KERNEL_DIM = 3;

   // fixed field widths
   localparam int ACTION_WIDTH     = 2;
   localparam int COORD_WIDTH      = 7;
   localparam int PIXEL_WIDTH      = 8;
   localparam int COEF_INDEX_WIDTH = 4;
   localparam int COEF_WIDTH       = 12;
   localparam int CSR_INDEX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH   = 16;
   localparam int GAIN_WIDTH       = 16;
   localparam int THRESH_WIDTH     = 13;
   localparam int BIAS_WIDTH       = 16;
   localparam int DIM_WIDTH        = 8;
   // internal coordinate width: holds MAX_WIDTH/MAX_HEIGHT up to 1024 plus kernel offsets
   localparam int POS_WIDTH        = 11;
   // scale operand is the unsigned gain with a sign bit on top
   localparam int SCALE_B_WIDTH    = GAIN_WIDTH + 1;

   // actions
   localparam logic [ACTION_WIDTH-1:0] ACT_PIXEL   = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_COEF    = 2'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_COMPUTE = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WIDTH     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEIGHT    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THRESHOLD = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BIAS      = 3'd4;

   // register reset values
   localparam logic [DIM_WIDTH-1:0]  RST_WIDTH  = 8'd128;
   localparam logic [DIM_WIDTH-1:0]  RST_HEIGHT = 8'd128;
   localparam logic [GAIN_WIDTH-1:0] RST_GAIN   = 16'd256;

   // saturation limits
   localparam logic [PIXEL_WIDTH-1:0] PIXEL_MAX = 8'd255;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_SCALE,
      ST_ABS,
      ST_DONE
   } state_type;

   // control of the shared multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic en;
      logic accumulate;
   } mac_ctrl_type;

endpackage

// ===== rtl/core/efth_ram.sv =====
// Generic single-port RAM with registered read.
module efth_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/efth_mac.sv =====
// Shared signed multiply-accumulate unit: taps during the sum, gain during scaling.
module efth_mac #(
   parameter int AW = 25,
   parameter int BW = 17,
   parameter int RW = 42
) (
   input  logic                   clock,
   input  efth_pkg::mac_ctrl_type ctrl,
   input  logic signed [AW-1:0]   a,
   input  logic signed [BW-1:0]   b,
   output logic signed [RW-1:0]   res
);

   import efth_pkg::*;

   logic signed [RW-1:0] prod;
   logic signed [RW-1:0] res_ff;
   logic signed [RW-1:0] res_in;

   assign prod = RW'(a) * RW'(b);

   always_comb begin
      res_in = res_ff;
      if (ctrl.clear) begin
         res_in = '0;
      end else if (ctrl.en) begin
         res_in = ctrl.accumulate ? res_ff + prod : prod;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

// ===== rtl/core/edge_filter_3x3_threshold_top.sv =====
// Top level of the thresholded 3x3 edge filter over a stored grayscale frame.
// Pixel and coefficient words are taken in idle without leaving it; req_stall stays low in idle.
// Compute word: the taps are read one pixel per cycle from the single-port frame RAM (READ),
// the last pixel drains (DRAIN), the one shared multiplier scales the sum (SCALE), the magnitude
// is taken (ABS) and the output register is loaded (DONE); next word taken while result waits.
// Synchronous reset clears sequencer, output valid, taps and registers; frame RAM is not reset.
module edge_filter_3x3_threshold_top #(
   parameter int MAX_WIDTH  = efth_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = efth_pkg::DEF_MAX_HEIGHT,
   parameter int KERNEL_DIM = efth_pkg::DEF_KERNEL_DIM
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [efth_pkg::ACTION_WIDTH-1:0]      req_action,
   input  logic [efth_pkg::COORD_WIDTH-1:0]       req_x,
   input  logic [efth_pkg::COORD_WIDTH-1:0]       req_y,
   input  logic [efth_pkg::PIXEL_WIDTH-1:0]       req_pixel_value,
   input  logic [efth_pkg::COEF_INDEX_WIDTH-1:0]  req_coef_index,
   input  logic signed [efth_pkg::COEF_WIDTH-1:0] req_coef_value,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [efth_pkg::PIXEL_WIDTH-1:0]       rsp_out_pixel,
   // register write port
   input  logic                                   csr_we,
   input  logic [efth_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [efth_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   import efth_pkg::*;

   // geometry
   localparam int TAP_COUNT = KERNEL_DIM * KERNEL_DIM;
   // only taps reachable by the 4-bit index are stored; the rest stay zero
   localparam int TAP_STORE = (TAP_COUNT < (1 << COEF_INDEX_WIDTH)) ?
                              TAP_COUNT : (1 << COEF_INDEX_WIDTH);
   localparam int TIW = (TAP_STORE > 1) ? $clog2(TAP_STORE) : 1;
   localparam int KIW = $clog2(TAP_COUNT + 1);
   localparam int KW  = $clog2(KERNEL_DIM + 1);
   localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int RAM_AW    = XW + YW;
   localparam int RAM_DEPTH = 1 << RAM_AW;
   // sum of products of 8-bit unsigned pixels and 12-bit signed taps
   localparam int SW = PIXEL_WIDTH + COEF_WIDTH + 1 + $clog2(TAP_COUNT);
   // scaled product width
   localparam int RW = SW + SCALE_B_WIDTH;
   // Q.16 bias term: the kept low bits of tmp plus the sign and carry
   localparam int FW = PIXEL_WIDTH + 2 * 8 + 2;

   localparam logic signed [SW-1:0] SUM_LIMIT = SW'(255 * 256);
   localparam logic [RW-1:0]        TMP_LIMIT = RW'(255 * 65536);

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [DIM_WIDTH-1:0]           width_ff;
   logic [DIM_WIDTH-1:0]           height_ff;
   logic [GAIN_WIDTH-1:0]          gain_ff;
   logic signed [THRESH_WIDTH-1:0] thresh_ff;
   logic signed [BIAS_WIDTH-1:0]   bias_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_WIDTH;
         height_ff <= RST_HEIGHT;
         gain_ff   <= RST_GAIN;
         thresh_ff <= '0;
         bias_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:     width_ff  <= csr_wdata[DIM_WIDTH-1:0];
            CSR_HEIGHT:    height_ff <= csr_wdata[DIM_WIDTH-1:0];
            CSR_GAIN:      gain_ff   <= csr_wdata[GAIN_WIDTH-1:0];
            CSR_THRESHOLD: thresh_ff <= csr_wdata[THRESH_WIDTH-1:0];
            CSR_BIAS:      bias_ff   <= csr_wdata[BIAS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // effective image size, saturated to the store
   logic [POS_WIDTH-1:0] width_eff;
   logic [POS_WIDTH-1:0] height_eff;

   assign width_eff  = (POS_WIDTH'(width_ff) > POS_WIDTH'(MAX_WIDTH)) ?
                       POS_WIDTH'(MAX_WIDTH) : POS_WIDTH'(width_ff);
   assign height_eff = (POS_WIDTH'(height_ff) > POS_WIDTH'(MAX_HEIGHT)) ?
                       POS_WIDTH'(MAX_HEIGHT) : POS_WIDTH'(height_ff);

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   state_type state_ff;
   state_type state_in;

   logic req_accept;
   logic rsp_accept;
   logic rsp_load;
   logic rsp_valid_ff;
   logic [PIXEL_WIDTH-1:0] rsp_pixel_ff;
   logic [PIXEL_WIDTH-1:0] rsp_pixel_in;

   logic [COORD_WIDTH-1:0] x_ff;
   logic [COORD_WIDTH-1:0] y_ff;
   logic [KW-1:0]          m_ff;
   logic [KW-1:0]          n_ff;
   logic [KIW-1:0]         k_ff;
   logic                   last_tap;

   // read pipeline: one word behind the RAM address
   logic                         d_valid_ff;
   logic                         d_range_ff;
   logic signed [COEF_WIDTH-1:0] d_tap_ff;

   logic signed [COEF_WIDTH-1:0] taps_ff [TAP_STORE];
   logic signed [COEF_WIDTH-1:0] tap_cur;

   logic [POS_WIDTH-1:0] pos_x;
   logic [POS_WIDTH-1:0] pos_y;
   logic [POS_WIDTH-1:0] wr_x;
   logic [POS_WIDTH-1:0] wr_y;
   logic                 rd_in_range;
   logic                 wr_in_store;

   logic                ram_we;
   logic [RAM_AW-1:0]   ram_addr;
   logic [PIXEL_WIDTH-1:0] ram_rdata;

   mac_ctrl_type               mac_ctrl;
   logic signed [SW-1:0]            mac_a;
   logic signed [SCALE_B_WIDTH-1:0] mac_b;
   logic signed [RW-1:0]            mac_res;
   logic signed [SW-1:0]            sum;
   logic [PIXEL_WIDTH-1:0]          pix_eff;

   logic                 below_ff;
   logic                 over_ff;
   logic [RW-1:0]        tmp_ff;
   logic signed [SW-1:0] thresh_scaled;
   logic signed [FW-1:0] biased;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);

   assign last_tap = (m_ff == KW'(KERNEL_DIM - 1)) && (n_ff == KW'(KERNEL_DIM - 1));

   // tap addressing
   assign pos_x       = POS_WIDTH'(x_ff) + POS_WIDTH'(m_ff);
   assign pos_y       = POS_WIDTH'(y_ff) + POS_WIDTH'(n_ff);
   assign rd_in_range = (pos_x < width_eff) && (pos_y < height_eff);
   assign wr_x        = POS_WIDTH'(req_x);
   assign wr_y        = POS_WIDTH'(req_y);
   assign wr_in_store = (wr_x < POS_WIDTH'(MAX_WIDTH)) && (wr_y < POS_WIDTH'(MAX_HEIGHT));
   assign tap_cur     = (k_ff < KIW'(TAP_STORE)) ? taps_ff[k_ff[TIW-1:0]] : '0;

   always_comb begin
      state_in = state_ff;
      mac_ctrl = '0;
      ram_we   = 1'b0;
      ram_addr = {pos_y[YW-1:0], pos_x[XW-1:0]};
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            ram_addr = {wr_y[YW-1:0], wr_x[XW-1:0]};
            if (req_accept) begin
               ram_we = (req_action == ACT_PIXEL) && wr_in_store;
               if (req_action == ACT_COMPUTE) begin
                  mac_ctrl.clear = 1'b1;
                  state_in       = ST_READ;
               end
            end
         end
         ST_READ: begin
            mac_ctrl.en         = d_valid_ff;
            mac_ctrl.accumulate = 1'b1;
            if (last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last pixel arrives from the RAM
            mac_ctrl.en         = d_valid_ff;
            mac_ctrl.accumulate = 1'b1;
            state_in            = ST_SCALE;
         end
         ST_SCALE: begin
            // sum times gain overwrites the accumulator
            mac_ctrl.en = 1'b1;
            state_in    = ST_ABS;
         end
         ST_ABS: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // kernel taps
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAP_STORE; i++) begin
            taps_ff[i] <= '0;
         end
      end else if (state_ff == ST_IDLE && req_accept && req_action == ACT_COEF &&
                   (5'(req_coef_index) < 5'(TAP_STORE))) begin
         taps_ff[req_coef_index[TIW-1:0]] <= req_coef_value;
      end
   end

   // tap walk: column m fastest, then row n
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_accept) begin
         x_ff <= req_x;
         y_ff <= req_y;
         m_ff <= '0;
         n_ff <= '0;
         k_ff <= '0;
      end else if (state_ff == ST_READ) begin
         k_ff <= k_ff + KIW'(1);
         if (m_ff == KW'(KERNEL_DIM - 1)) begin
            m_ff <= '0;
            n_ff <= n_ff + KW'(1);
         end else begin
            m_ff <= m_ff + KW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= (state_ff == ST_READ);
      end
   end

   always_ff @(posedge clock) begin
      d_range_ff <= rd_in_range;
      d_tap_ff   <= tap_cur;
   end

   efth_ram #(
      .WIDTH (PIXEL_WIDTH),
      .DEPTH (RAM_DEPTH)
   ) u_frame (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_pixel_value),
      .rdata (ram_rdata)
   );

   // ---------------------------------------------------------------------
   // shared multiplier operands
   // ---------------------------------------------------------------------
   assign sum     = mac_res[SW-1:0];
   assign pix_eff = d_range_ff ? ram_rdata : '0;

   always_comb begin
      if (state_ff == ST_SCALE) begin
         mac_a = sum;
         mac_b = SCALE_B_WIDTH'(gain_ff);
      end else begin
         mac_a = SW'(pix_eff);
         mac_b = SCALE_B_WIDTH'(d_tap_ff);
      end
   end

   efth_mac #(
      .AW (SW),
      .BW (SCALE_B_WIDTH),
      .RW (RW)
   ) u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .a     (mac_a),
      .b     (mac_b),
      .res   (mac_res)
   );

   // ---------------------------------------------------------------------
   // threshold, magnitude, clamp and bias
   // ---------------------------------------------------------------------
   assign thresh_scaled = SW'(thresh_ff) <<< 8;

   // flags are taken from the raw sum before the scale overwrites it
   always_ff @(posedge clock) begin
      if (state_ff == ST_SCALE) begin
         below_ff <= (sum < thresh_scaled);
         over_ff  <= (sum > SUM_LIMIT);
      end
      if (state_ff == ST_ABS) begin
         tmp_ff <= mac_res[RW-1] ? RW'(-mac_res) : RW'(mac_res);
      end
   end

   // tmp is below 2^24 whenever this path is used; floor of a signed Q.16 value
   assign biased = FW'({1'b0, tmp_ff[23:0]}) + (FW'(bias_ff) <<< 8);

   always_comb begin
      if (below_ff) begin
         rsp_pixel_in = '0;
      end else if (over_ff || tmp_ff > TMP_LIMIT) begin
         rsp_pixel_in = PIXEL_MAX;
      end else begin
         rsp_pixel_in = biased[23:16];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pixel_ff <= rsp_pixel_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_pixel = rsp_pixel_ff;

endmodule

// ===== dv/edge_filter_3x3_threshold_top_tb.sv =====
// Self-checking testbench for the thresholded 3x3 edge filter: predicted output bytes vs DUT.
module edge_filter_3x3_threshold_top_tb;
   import efth_pkg::*;

   localparam int STORE_W   = DEF_MAX_WIDTH;
   localparam int STORE_H   = DEF_MAX_HEIGHT;
   localparam int KDIM      = DEF_KERNEL_DIM;
   localparam int TAP_COUNT = KDIM * KDIM;

   // spare action code, decoded as nothing
   localparam logic [ACTION_WIDTH-1:0] ACT_UNUSED = 2'd3;

   // quiet time before a register write: longer than one compute word
   localparam int SETTLE_CYCLES  = 24;
   // cycles with no handshake of any kind before the run is called hung
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic [ACTION_WIDTH-1:0]            action;
      logic [COORD_WIDTH-1:0]             x;
      logic [COORD_WIDTH-1:0]             y;
      logic [PIXEL_WIDTH-1:0]             pixel;
      logic [COEF_INDEX_WIDTH-1:0]        cidx;
      logic signed [COEF_WIDTH-1:0]       cval;
   } filter_word_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic [ACTION_WIDTH-1:0]             req_action;
   logic [COORD_WIDTH-1:0]              req_x;
   logic [COORD_WIDTH-1:0]              req_y;
   logic [PIXEL_WIDTH-1:0]              req_pixel_value;
   logic [COEF_INDEX_WIDTH-1:0]         req_coef_index;
   logic signed [COEF_WIDTH-1:0]        req_coef_value;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic [PIXEL_WIDTH-1:0]              rsp_out_pixel;
   logic                                csr_we;
   logic [CSR_INDEX_WIDTH-1:0]          csr_index;
   logic [CSR_DATA_WIDTH-1:0]           csr_wdata;

   // words waiting for the driver, and output bytes waiting for the DUT
   filter_word_type                     pending_words[$];
   logic [PIXEL_WIDTH-1:0]              expected_pixels[$];

   // predictor state, updated on accepted handshakes and register writes only
   logic [PIXEL_WIDTH-1:0]              frame_img [STORE_W*STORE_H];
   logic signed [COEF_WIDTH-1:0]        taps [TAP_COUNT];
   logic [DIM_WIDTH-1:0]                img_w;
   logic [DIM_WIDTH-1:0]                img_h;
   logic [GAIN_WIDTH-1:0]               gain;
   logic signed [THRESH_WIDTH-1:0]      thr;
   logic signed [BIAS_WIDTH-1:0]        bias_q;

   // stimulus-side bookkeeping: which pixels have been written, and the
   // effective image size the generator is working to
   bit                                  pix_known [STORE_W*STORE_H];
   int                                  gen_w;
   int                                  gen_h;

   int                                  words_queued;
   int                                  words_taken;
   int                                  err_count;
   int                                  idle_count;
   int                                  send_gap;
   int                                  stall_left;
   bit                                  idling_on;
   bit                                  req_taken;

   edge_filter_3x3_threshold_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_x           (req_x),
      .req_y           (req_y),
      .req_pixel_value (req_pixel_value),
      .req_coef_index  (req_coef_index),
      .req_coef_value  (req_coef_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_pixel   (rsp_out_pixel),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // Kernel sum in Q.8, threshold, gain to Q.16, clamp, then bias and wrap.
   function automatic logic [PIXEL_WIDTH-1:0] filter_output(int cx, int cy);
      int                 w_eff;
      int                 h_eff;
      int                 px;
      int                 py;
      logic signed [63:0] acc;
      logic signed [63:0] mag;
      w_eff = (img_w > STORE_W) ? STORE_W : int'(img_w);
      h_eff = (img_h > STORE_H) ? STORE_H : int'(img_h);
      acc   = 0;
      for (int n = 0; n < KDIM; n++) begin
         for (int m = 0; m < KDIM; m++) begin
            px = cx + m;
            py = cy + n;
            // taps past the edge of the image count as zero
            if (px < w_eff && py < h_eff)
               acc += $signed({1'b0, frame_img[py*STORE_W + px]}) * taps[m + KDIM*n];
         end
      end
      if (acc < thr * 256)
         return '0;
      mag = acc * $signed({1'b0, gain});
      if (mag < 0)
         mag = -mag;
      if (acc > 255 * 256 || mag > 255 * 65536)
         return PIXEL_MAX;
      // floored, so a negative bias wraps through the low byte
      mag += bias_q * 256;
      return mag[23:16];
   endfunction

   function automatic void apply_word(filter_word_type w);
      case (w.action)
         ACT_PIXEL: begin
            frame_img[w.y * STORE_W + w.x] = w.pixel;
         end
         ACT_COEF: begin
            if (w.cidx < TAP_COUNT)
               taps[w.cidx] = w.cval;
         end
         ACT_COMPUTE: begin
            expected_pixels.push_back(filter_output(w.x, w.y));
         end
         default: ;
      endcase
   endfunction

   function automatic void apply_csr(logic [CSR_INDEX_WIDTH-1:0] idx,
                                     logic [CSR_DATA_WIDTH-1:0] data);
      case (idx)
         CSR_WIDTH:     img_w  = data[DIM_WIDTH-1:0];
         CSR_HEIGHT:    img_h  = data[DIM_WIDTH-1:0];
         CSR_GAIN:      gain   = data[GAIN_WIDTH-1:0];
         CSR_THRESHOLD: thr    = data[THRESH_WIDTH-1:0];
         CSR_BIAS:      bias_q = data[BIAS_WIDTH-1:0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus

   // every field random; callers overwrite the ones that matter
   function automatic filter_word_type blank_word();
      filter_word_type w;
      w.action = ACTION_WIDTH'($urandom);
      w.x      = COORD_WIDTH'($urandom);
      w.y      = COORD_WIDTH'($urandom);
      w.pixel  = PIXEL_WIDTH'($urandom);
      w.cidx   = COEF_INDEX_WIDTH'($urandom);
      w.cval   = COEF_WIDTH'($urandom);
      return w;
   endfunction

   function automatic void push_word(filter_word_type w);
      pending_words.push_back(w);
      words_queued++;
   endfunction

   function automatic void push_pixel(int px, int py, int v);
      filter_word_type w;
      w        = blank_word();
      w.action = ACT_PIXEL;
      w.x      = COORD_WIDTH'(px);
      w.y      = COORD_WIDTH'(py);
      w.pixel  = PIXEL_WIDTH'(v);
      pix_known[py*STORE_W + px] = 1'b1;
      push_word(w);
   endfunction

   function automatic void push_coef(int idx, int v);
      filter_word_type w;
      w        = blank_word();
      w.action = ACT_COEF;
      w.cidx   = COEF_INDEX_WIDTH'(idx);
      w.cval   = COEF_WIDTH'(v);
      push_word(w);
   endfunction

   // Any tap inside the image that has never been written gets a random
   // pixel first: the frame RAM holds garbage until written.
   function automatic void push_compute(int cx, int cy);
      filter_word_type w;
      int              px;
      int              py;
      for (int n = 0; n < KDIM; n++) begin
         for (int m = 0; m < KDIM; m++) begin
            px = cx + m;
            py = cy + n;
            if (px < gen_w && py < gen_h && !pix_known[py*STORE_W + px])
               push_pixel(px, py, $urandom_range(0, 255));
         end
      end
      w        = blank_word();
      w.action = ACT_COMPUTE;
      w.x      = COORD_WIDTH'(cx);
      w.y      = COORD_WIDTH'(cy);
      push_word(w);
   endfunction

   // Block until every queued word is taken and every output byte is back,
   // then give the last non-result word time to retire.
   task automatic wait_quiet();
      do
         @(negedge clock);
      while (words_taken != words_queued || expected_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Upper bits above each register's width are junk and must be dropped.
   task automatic write_regs(int w, int h, int g, int t, int b);
      wait_quiet();
      write_csr(CSR_WIDTH, {8'($urandom), 8'(w)});
      write_csr(CSR_HEIGHT, {8'($urandom), 8'(h)});
      write_csr(CSR_GAIN, 16'(g));
      write_csr(CSR_THRESHOLD, {3'($urandom), 13'(t)});
      write_csr(CSR_BIAS, 16'(b));
      // index past the register list: no effect
      write_csr(CSR_INDEX_WIDTH'(CSR_BIAS + 1 + $urandom_range(0, 2)), 16'($urandom));
      gen_w = (w > STORE_W) ? STORE_W : w;
      gen_h = (h > STORE_H) ? STORE_H : h;
      @(posedge clock);
   endtask

   // Mostly computes near the origin so pixels get reused; a tenth land
   // anywhere in the store. Coefficients mostly small so outputs avoid
   // the clamps, with full-range ones and out-of-range indexes mixed in.
   task automatic random_traffic(int n_words);
      int              roll;
      int              sx;
      int              sy;
      int              idx;
      int              v;
      filter_word_type w;
      for (int i = 0; i < n_words; i++) begin
         roll = $urandom_range(0, 99);
         sx   = (gen_w > 14) ? 15 : gen_w + 1;
         sy   = (gen_h > 14) ? 15 : gen_h + 1;
         if (roll < 55) begin
            if ($urandom_range(0, 9) == 0)
               push_compute($urandom_range(0, 127), $urandom_range(0, 127));
            else
               push_compute($urandom_range(0, sx), $urandom_range(0, sy));
         end else if (roll < 75) begin
            if ($urandom_range(0, 9) == 0)
               push_pixel($urandom_range(0, 127), $urandom_range(0, 127),
                          $urandom_range(0, 255));
            else
               push_pixel($urandom_range(0, sx), $urandom_range(0, sy),
                          $urandom_range(0, 255));
         end else if (roll < 93) begin
            if ($urandom_range(0, 7) == 0)
               idx = $urandom_range(TAP_COUNT, 15);
            else
               idx = $urandom_range(0, TAP_COUNT - 1);
            if ($urandom_range(0, 3) == 0)
               v = $signed(COEF_WIDTH'($urandom));
            else
               v = $urandom_range(0, 192) - 96;
            push_coef(idx, v);
         end else begin
            w        = blank_word();
            w.action = ACT_UNUSED;
            push_word(w);
         end
      end
   endtask

   // ---------------------------------------------------------------- driver

   // Hold the word until taken; after each word maybe leave a short gap.
   always @(negedge clock) begin
      filter_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            w = pending_words.pop_front();
            req_action      <= w.action;
            req_x           <= w.x;
            req_y           <= w.y;
            req_pixel_value <= w.pixel;
            req_coef_index  <= w.cidx;
            req_coef_value  <= w.cval;
            req_valid       <= 1'b1;
            if (idling_on && $urandom_range(0, 3) == 0)
               send_gap = $urandom_range(1, 3);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure in bursts, independent of rsp_valid.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (idling_on && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 3);
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      filter_word_type        seen;
      logic [PIXEL_WIDTH-1:0] want;
      bit                     progress;
      req_taken = 1'b0;
      if (reset) begin
         foreach (taps[i])
            taps[i] = '0;
         img_w      = RST_WIDTH;
         img_h      = RST_HEIGHT;
         gain       = RST_GAIN;
         thr        = '0;
         bias_q     = '0;
         idle_count = 0;
      end else begin
         progress = csr_we;
         if (rsp_valid && !rsp_stall) begin
            progress = 1'b1;
            if (expected_pixels.size() == 0) begin
               $display("%0t: out_pixel expected none, got %0d", $time, rsp_out_pixel);
               err_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_out_pixel !== want) begin
                  $display("%0t: out_pixel expected %0d, got %0d", $time, want, rsp_out_pixel);
                  err_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            progress    = 1'b1;
            req_taken   = 1'b1;
            seen.action = req_action;
            seen.x      = req_x;
            seen.y      = req_y;
            seen.pixel  = req_pixel_value;
            seen.cidx   = req_coef_index;
            seen.cval   = req_coef_value;
            words_taken++;
            apply_word(seen);
         end
         if (csr_we)
            apply_csr(csr_index, csr_wdata);
         idle_count = progress ? 0 : idle_count + 1;
         if (idle_count >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[edge_filter_3x3_threshold_top] ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      filter_word_type w;
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_action      = ACT_PIXEL;
      req_x           = '0;
      req_y           = '0;
      req_pixel_value = '0;
      req_coef_index  = '0;
      req_coef_value  = '0;
      rsp_stall       = 1'b0;
      csr_we          = 1'b0;
      csr_index       = CSR_WIDTH;
      csr_wdata       = '0;
      words_queued    = 0;
      words_taken     = 0;
      err_count       = 0;
      idling_on       = 1'b1;
      gen_w           = STORE_W;
      gen_h           = STORE_H;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset registers, extreme taps, corners of the store
      push_coef(0, -2048);
      push_coef(8, 2047);
      push_coef(4, 1024);
      push_coef(1, -256);
      push_coef(3, -256);
      push_coef(15, 77);            // index past the kernel: ignored
      push_pixel(0, 0, 255);
      push_pixel(127, 127, 0);
      push_compute(0, 0);
      push_compute(127, 127);       // only the corner tap is inside
      push_compute(126, 0);
      w        = blank_word();
      w.action = ACT_UNUSED;
      push_word(w);
      push_coef(2, 255);
      push_pixel(127, 0, 128);
      push_compute(0, 0);
      push_compute(125, 126);

      // small image, threshold at its floor
      write_regs(8, 6, 256, -4096, 0);
      random_traffic(300);

      // 1x1 image, every other register at its top
      write_regs(1, 1, 65535, 4095, 32767);
      random_traffic(120);

      // width/height beyond the store saturate; zero gain, bias at its floor
      write_regs(255, 200, 0, -100, -32768);
      random_traffic(150);

      // zero width: every tap reads zero
      write_regs(0, 5, $urandom_range(0, 65535), $urandom_range(0, 40) - 20,
                 $urandom_range(0, 65535) - 32768);
      random_traffic(100);

      write_regs(12, 10, $urandom_range(128, 512), $urandom_range(0, 80) - 40,
                 $urandom_range(0, 65535) - 32768);
      random_traffic(500);

      write_regs(128, 3, $urandom_range(0, 65535), $urandom_range(0, 400) - 200,
                 $urandom_range(0, 65535) - 32768);
      random_traffic(300);

      // last stretch runs flat out on both sides
      write_regs(7, 128, $urandom_range(200, 700), $urandom_range(0, 40) - 20,
                 $urandom_range(0, 65535) - 32768);
      idling_on = 1'b0;
      random_traffic(300);

      wait_quiet();
      if (err_count == 0)
         $display("[edge_filter_3x3_threshold_top] OK");
      else
         $display("[edge_filter_3x3_threshold_top] ERROR");
      $finish;
   end

endmodule
